// File: rtl/gcb_pkg.sv
`timescale 1ns / 1ps
// gcb_pkg: shared widths, command codes and the color pick function for the graph
// coloring search. Depends on nothing.
package gcb_pkg;

	localparam int COLOR_W    = 4;
	localparam int NUM_CODES  = 1 << COLOR_W;
	localparam int VTX_W      = 3;
	localparam int ROW_W      = 8;
	localparam int ADJ_DEPTH  = 8;
	localparam int ADJ_AW     = 3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef logic [NUM_CODES-1:0] color_mask_t;
	typedef logic [COLOR_W-1:0]   color_t;

	// lowest color above own that is not used by a neighbor and not above m
	// msb of the result says whether one exists
	function automatic logic [COLOR_W:0] pick_color(
		input color_mask_t busy,
		input color_t      own,
		input color_t      m
	);
		logic [COLOR_W:0] r;
		r = '0;
		for (int c = NUM_CODES - 1; c >= 1; c--) begin
			if (c > int'(own) && c <= int'(m) && !busy[c]) begin
				r = {1'b1, COLOR_W'(c)};
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/gcb_ram.sv
`timescale 1ns / 1ps
// gcb_ram: generic single write port, single read port ram with registered read.
// No dependencies.
module gcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/graph_coloring_backtrack.sv
`timescale 1ns / 1ps
// graph_coloring_backtrack: m-coloring of a small graph by backtracking search.
// Depends on gcb_pkg and gcb_ram.
//
// A load request (cmd 0) writes one adjacency row at its handshake; rows for
// vertices at or above N_VERTICES are dropped. A start request (cmd 1) clears all
// colors, one vertex at a time, then searches vertex by vertex in ascending order,
// giving each vertex the lowest color above its current one, up to num_colors,
// not held by a lower neighbor in its own row, and backtracking when none is left.
// A visit of vertex v reads its adjacency row, then reads the color ram once per
// lower vertex plus the vertex itself, so the color ram read port sets the search
// time, which grows with the number of trials. A found coloring comes out as one
// result per vertex, read from the color ram and then loaded into the output
// register, with last on the final one; no coloring gives one result with found,
// out_vertex and out_color zero and last set. num_colors resets to 3 and is written
// through the cfg port, which is always ready; write it only while no search is
// running. New requests are taken only when no search or report is in progress.
module graph_coloring_backtrack #(
	parameter int N_VERTICES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gcb_pkg::COLOR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [gcb_pkg::VTX_W-1:0]     row_vertex,
	input  logic [gcb_pkg::ROW_W-1:0]     adjacency_row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [gcb_pkg::VTX_W-1:0]     out_vertex,
	output logic [gcb_pkg::COLOR_W-1:0]   out_color,
	output logic                          last
);
	import gcb_pkg::*;

	localparam int VW = $clog2(N_VERTICES);
	localparam logic [VW-1:0] V_LAST = VW'(N_VERTICES - 1);

	// search sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CLEAR   = 4'd1;
	localparam logic [3:0] ST_VISIT   = 4'd2;
	localparam logic [3:0] ST_ADJ     = 4'd3;
	localparam logic [3:0] ST_SCAN    = 4'd4;
	localparam logic [3:0] ST_DECIDE  = 4'd5;
	localparam logic [3:0] ST_FAIL    = 4'd6;
	localparam logic [3:0] ST_EMIT_RD = 4'd7;
	localparam logic [3:0] ST_EMIT_LD = 4'd8;

	logic [3:0]           state_q;
	color_t               num_colors_q;
	logic [ADJ_DEPTH-1:0] adj_valid_q;   // row written since reset
	logic [VW-1:0]        v_q;           // vertex being colored
	logic [VW-1:0]        k_q;           // clear / report index
	logic [VW-1:0]        iss_q;         // next color read in the scan
	logic                 iss_done_q;
	logic                 rd_vld_s1;     // color read in flight
	logic [VW-1:0]        rd_idx_s1;
	logic                 adj_hit_s1;    // adjacency read hits a written row
	logic [ROW_W-1:0]     adj_q;
	color_mask_t          mask_q;        // colors held by lower neighbors
	color_t               own_q;         // current color of v

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	logic [COLOR_W:0]     pick;

	// adjacency ram
	logic                 adj_we;
	logic [ADJ_AW-1:0]    adj_waddr;
	logic [ROW_W-1:0]     adj_rdata;

	// color ram
	logic                 col_we;
	logic [VW-1:0]        col_waddr;
	color_t               col_wdata;
	logic [VW-1:0]        col_raddr;
	color_t               col_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	// output register free now or at this edge
	assign out_free  = !out_valid || out_ready;
	// output register takes a new result at this edge
	assign out_load  = (state_q == ST_FAIL && out_free) || (state_q == ST_EMIT_LD);
	assign pick      = pick_color(mask_q, own_q, num_colors_q);

	assign adj_we    = in_acc && (cmd == CMD_LOAD) && (int'(row_vertex) < N_VERTICES);
	assign adj_waddr = row_vertex;

	gcb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ADJ_DEPTH)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adjacency_row),
		.raddr(ADJ_AW'(v_q)),
		.rdata(adj_rdata)
	);

	// color ram ports
	always_comb begin
		col_we    = 1'b0;
		col_waddr = v_q;
		col_wdata = '0;
		col_raddr = iss_q;
		case (state_q)
			ST_CLEAR: begin
				col_we    = 1'b1;
				col_waddr = k_q;
			end
			ST_DECIDE: begin
				// placed color or zero when backing out of this vertex
				col_we    = 1'b1;
				col_wdata = pick[COLOR_W] ? pick[COLOR_W-1:0] : '0;
			end
			ST_EMIT_RD: begin
				col_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	gcb_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(N_VERTICES)
	) u_color_ram (
		.clk  (clk),
		.we   (col_we),
		.waddr(col_waddr),
		.wdata(col_wdata),
		.raddr(col_raddr),
		.rdata(col_rdata)
	);

	// config register and adjacency valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q <= COLOR_W'(3);
			adj_valid_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_colors_q <= cfg_data;
			end
			if (adj_we) begin
				adj_valid_q[adj_waddr] <= 1'b1;
			end
		end
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			v_q        <= '0;
			k_q        <= '0;
			iss_q      <= '0;
			iss_done_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && cmd == CMD_START) begin
						k_q     <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (k_q == V_LAST) begin
						v_q     <= '0;
						state_q <= ST_VISIT;
					end else begin
						k_q <= k_q + VW'(1);
					end
				end
				ST_VISIT: begin
					// adjacency row of v is read this cycle
					state_q <= ST_ADJ;
				end
				ST_ADJ: begin
					iss_q      <= '0;
					iss_done_q <= 1'b0;
					rd_vld_s1  <= 1'b0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					// one color read per cycle over vertices 0..v
					rd_vld_s1 <= !iss_done_q;
					if (!iss_done_q) begin
						if (iss_q == v_q) begin
							iss_done_q <= 1'b1;
						end else begin
							iss_q <= iss_q + VW'(1);
						end
					end
					if (iss_done_q && !rd_vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (pick[COLOR_W]) begin
						if (v_q == V_LAST) begin
							k_q     <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							v_q     <= v_q + VW'(1);
							state_q <= ST_VISIT;
						end
					end else begin
						if (v_q == '0) begin
							state_q <= ST_FAIL;
						end else begin
							v_q     <= v_q - VW'(1);
							state_q <= ST_VISIT;
						end
					end
				end
				ST_FAIL: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					// read only once the output register will be free to take it
					if (out_free) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					out_valid <= 1'b1;
					if (k_q == V_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + VW'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan datapath, no reset needed
	always_ff @(posedge clk) begin
		rd_idx_s1 <= iss_q;
		if (state_q == ST_VISIT) begin
			adj_hit_s1 <= (int'(v_q) < ADJ_DEPTH) && adj_valid_q[ADJ_AW'(v_q)];
		end
		if (state_q == ST_ADJ) begin
			// unwritten rows read as no edges
			adj_q  <= adj_hit_s1 ? adj_rdata : '0;
			mask_q <= '0;
			own_q  <= '0;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rd_idx_s1 == v_q) begin
				own_q <= col_rdata;
			end else if (int'(rd_idx_s1) < ADJ_DEPTH && adj_q[ADJ_AW'(rd_idx_s1)]) begin
				mask_q <= mask_q | (NUM_CODES'(1) << col_rdata);
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FAIL && out_free) begin
			found      <= 1'b0;
			out_vertex <= '0;
			out_color  <= '0;
			last       <= 1'b1;
		end else if (state_q == ST_EMIT_LD) begin
			found      <= 1'b1;
			out_vertex <= VTX_W'(k_q);
			out_color  <= col_rdata;
			last       <= (k_q == V_LAST);
		end
	end

endmodule

// File: tb/coloring_checker.sv
`timescale 1ns / 1ps
// coloring_checker: watches the config, request and result channels of the graph
// coloring block, predicts each search outcome and compares the results field by field.
// Depends on gcb_pkg.
module coloring_checker #(
	parameter int N_VERTICES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [gcb_pkg::COLOR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          cmd,
	input  logic [gcb_pkg::VTX_W-1:0]     row_vertex,
	input  logic [gcb_pkg::ROW_W-1:0]     adjacency_row,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          found,
	input  logic [gcb_pkg::VTX_W-1:0]     out_vertex,
	input  logic [gcb_pkg::COLOR_W-1:0]   out_color,
	input  logic                          last,
	output int                            mismatches,
	output int                            reports_due
);
	import gcb_pkg::*;

	typedef logic [VTX_W-1:0] vertex_t;
	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		logic    found;
		vertex_t vertex;
		color_t  color;
		logic    last;
	} coloring_report_t;

	localparam color_t PALETTE_AT_RESET = 4'd3;

	coloring_report_t coloring_reports[$];
	row_t             rows [N_VERTICES];
	color_t           palette;
	int               error_count = 0;
	int               reports_seen = 0;

	assign mismatches = error_count;

	task automatic flag_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch in result %0d, %s: got %0d, expected %0d at %0t",
			reports_seen, what, got, want, $time);
		error_count++;
	endtask

	// backtracking search over the rows as stored, expected reports queued in order
	task automatic solve_coloring();
		color_t           shade [N_VERTICES];
		coloring_report_t rep;
		int               v;
		int               j;
		int               col;
		logic             fits;
		for (v = 0; v < N_VERTICES; v++) shade[v] = '0;
		v = 0;
		while (v >= 0 && v < N_VERTICES) begin
			col = int'(shade[v]) + 1;
			fits = 1'b0;
			while (!fits && col <= int'(palette)) begin
				fits = 1'b1;
				// self loops skipped, only the row of v is consulted
				for (j = 0; j < N_VERTICES && j < ROW_W; j++)
					if (j != v && rows[v][j] && int'(shade[j]) == col) fits = 1'b0;
				if (!fits) col++;
			end
			if (fits) begin
				shade[v] = color_t'(col);
				v++;
			end else begin
				shade[v] = '0;
				v--;
			end
		end
		if (v >= N_VERTICES) begin
			for (v = 0; v < N_VERTICES; v++) begin
				rep.found = 1'b1;
				rep.vertex = vertex_t'(v);
				rep.color = shade[v];
				rep.last = (v == N_VERTICES - 1);
				coloring_reports.push_back(rep);
			end
		end else begin
			rep = '0;
			rep.last = 1'b1;
			coloring_reports.push_back(rep);
		end
	endtask

	task automatic check_report();
		coloring_report_t want;
		if (coloring_reports.size() == 0) begin
			flag_mismatch("result with none pending", {found, out_vertex, out_color[3:0]},
				8'd0);
		end else begin
			want = coloring_reports.pop_front();
			if (found !== want.found) flag_mismatch("found", 8'(found), 8'(want.found));
			if (out_vertex !== want.vertex)
				flag_mismatch("out_vertex", 8'(out_vertex), 8'(want.vertex));
			if (out_color !== want.color)
				flag_mismatch("out_color", 8'(out_color), 8'(want.color));
			if (last !== want.last) flag_mismatch("last", 8'(last), 8'(want.last));
		end
		reports_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_VERTICES; i++) rows[i] = '0;
			palette = PALETTE_AT_RESET;
			coloring_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready) palette = cfg_data;
			if (out_valid && out_ready) check_report();
			if (in_valid && in_ready) begin
				if (cmd == CMD_LOAD) begin
					if (int'(row_vertex) < N_VERTICES) rows[row_vertex] = adjacency_row;
				end else begin
					solve_coloring();
				end
			end
		end
		reports_due = coloring_reports.size();
	end

endmodule

// File: tb/graph_coloring_backtrack_test.sv
`timescale 1ns / 1ps
// graph_coloring_backtrack_test: drives load and start requests and palette writes
// into the graph coloring block and gives the verdict. Depends on gcb_pkg,
// graph_coloring_backtrack and coloring_checker.
module graph_coloring_backtrack_test;
	import gcb_pkg::*;

	typedef logic [VTX_W-1:0] vertex_t;
	typedef logic [ROW_W-1:0] row_t;

	localparam int VERTICES      = 8;
	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int IDLE_PCT      = 36;
	localparam int RANDOM_ITEMS  = 460;
	// searches above this many vertex visits get thinned before start
	localparam int EFFORT_CAP    = 300;
	// a load is written at its handshake edge, allow plenty of settling
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int CALM_FROM     = 10000;
	localparam int CALM_TO       = 22000;
	localparam int LIMIT_CYCLES  = 2000000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    cfg_valid;
	logic    cfg_ready;
	color_t  cfg_data;
	logic    in_valid;
	logic    in_ready;
	logic    cmd;
	vertex_t row_vertex;
	row_t    adjacency_row;
	logic    out_valid;
	logic    out_ready;
	logic    found;
	vertex_t out_vertex;
	color_t  out_color;
	logic    last;
	int      mismatches;
	int      reports_due;

	int      cycle = 0;
	int      requests_sent = 0;
	// rows as the block holds them and the palette size, used to keep searches short
	row_t    shadow_rows [VERTICES];
	color_t  colors_avail;

	graph_coloring_backtrack #(
		.N_VERTICES(VERTICES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.row_vertex(row_vertex),
		.adjacency_row(adjacency_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.out_vertex(out_vertex),
		.out_color(out_color),
		.last(last)
	);

	coloring_checker #(
		.N_VERTICES(VERTICES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.row_vertex(row_vertex),
		.adjacency_row(adjacency_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.out_vertex(out_vertex),
		.out_color(out_color),
		.last(last),
		.mismatches(mismatches),
		.reports_due(reports_due)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
	end

	// window where neither side idles
	function automatic logic calm();
		return cycle >= CALM_FROM && cycle < CALM_TO;
	endfunction

	// one request; entered at a falling edge, returns at the falling edge after the
	// handshake with valid still up, so a following request goes out back to back
	task automatic send_request(input logic op, input vertex_t vtx, input row_t row);
		while (!calm() && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		row_vertex <= vtx;
		adjacency_row <= row;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if (op == CMD_LOAD) shadow_rows[vtx] = row;
		requests_sent++;
	endtask

	// start request, preceded by thinning loads while the search would run too long
	task automatic launch_search();
		color_t  trial [VERTICES];
		int      v;
		int      j;
		int      col;
		int      visits;
		logic    fits;
		logic    cheap;
		vertex_t pick;
		cheap = 1'b0;
		while (!cheap) begin
			for (v = 0; v < VERTICES; v++) trial[v] = '0;
			v = 0;
			visits = 0;
			while (v >= 0 && v < VERTICES && visits <= EFFORT_CAP) begin
				visits++;
				col = int'(trial[v]) + 1;
				fits = 1'b0;
				while (!fits && col <= int'(colors_avail)) begin
					fits = 1'b1;
					for (j = 0; j < VERTICES; j++)
						if (j != v && shadow_rows[v][j] && int'(trial[j]) == col) fits = 1'b0;
					if (!fits) col++;
				end
				if (fits) begin
					trial[v] = color_t'(col);
					v++;
				end else begin
					trial[v] = '0;
					v--;
				end
			end
			cheap = visits <= EFFORT_CAP;
			if (!cheap) begin
				pick = vertex_t'($urandom_range(VERTICES - 1));
				send_request(CMD_LOAD, pick, shadow_rows[pick] & row_t'($urandom));
			end
		end
		// vertex and row fields are don't care on start, send noise there
		send_request(CMD_START, vertex_t'($urandom), row_t'($urandom));
	endtask

	// palette write only with the block idle: inputs drained, every result back
	task automatic change_palette(input color_t m);
		in_valid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		colors_avail = m;
	endtask

	// result side: random stalls, a calm window, and two long holds taken while the
	// sender keeps offering so the block backs up into its input
	initial begin : receiver
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done < 2 && cycle >= (holds_done == 0 ? 3000 : 25000)
					&& out_valid === 1'b1 && in_valid === 1'b1) begin
				hold_left = HOLD_CYCLES - 1;
				holds_done++;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm() || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin : watchdog
		while (cycle < LIMIT_CYCLES) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		row_t   graph [VERTICES];
		color_t m;
		int     stop_at;
		int     kind;
		int     density;
		logic   mirror;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		row_vertex = '0;
		adjacency_row = '0;
		for (int v = 0; v < VERTICES; v++) shadow_rows[v] = '0;
		colors_avail = 4'd3;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no edges with the reset palette: every vertex takes the first color
		launch_search();
		// complete graph with self loops, three colors cannot cover it
		for (int v = 0; v < VERTICES; v++) send_request(CMD_LOAD, vertex_t'(v), '1);
		launch_search();
		// widest palette colors the complete graph 1..8
		change_palette(4'd15);
		launch_search();
		// edge to vertex 0 left only in row 0: vertex 1 may reuse its color
		send_request(CMD_LOAD, vertex_t'(1), row_t'(0));
		launch_search();
		// empty palette: nothing can be tried, not found
		change_palette(4'd0);
		launch_search();
		// self loops only, a single color must do
		change_palette(4'd1);
		for (int v = 0; v < VERTICES; v++)
			send_request(CMD_LOAD, vertex_t'(v), row_t'(1 << v));
		launch_search();
		change_palette(4'd2);
		send_request(CMD_LOAD, vertex_t'(7), row_t'(1));
		launch_search();

		stop_at = requests_sent + RANDOM_ITEMS;
		while (requests_sent < stop_at) begin
			case ($urandom_range(9))
				0: m = 4'd1;
				1: m = 4'd15;
				2: m = 4'd0;
				default: m = color_t'($urandom_range(6, 2));
			endcase
			change_palette(m);
			repeat ($urandom_range(5, 2)) begin
				kind = $urandom_range(99);
				if (kind < 70) begin
					// full graph load then start, density and symmetry vary per graph
					case ($urandom_range(3))
						0: density = 15;
						1: density = 35;
						2: density = 55;
						default: density = 80;
					endcase
					mirror = 1'($urandom_range(1));
					for (int v = 0; v < VERTICES; v++) graph[v] = '0;
					for (int v = 0; v < VERTICES; v++)
						for (int j = 0; j < VERTICES; j++)
							if ($urandom_range(99) < density) begin
								graph[v][j] = 1'b1;
								if (mirror) graph[j][v] = 1'b1;
							end
					for (int v = 0; v < VERTICES; v++)
						send_request(CMD_LOAD, vertex_t'(v), graph[v]);
					launch_search();
				end else if (kind < 85) begin
					// touch up a few rows of the graph already loaded
					repeat ($urandom_range(3, 1))
						send_request(CMD_LOAD, vertex_t'($urandom), row_t'($urandom));
					launch_search();
				end else begin
					// loose loads, sometimes followed by back to back starts
					repeat ($urandom_range(4, 1))
						send_request(CMD_LOAD, vertex_t'($urandom), row_t'($urandom));
					if ($urandom_range(1)) begin
						launch_search();
						launch_search();
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
